// ----- rtl/dpr_pkg.sv -----
// shared types, constants and helpers of the delta pagerank vertex engine
package dpr_pkg;

   localparam int VERTEX_COUNT_DEF = 4096;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic signed [31:0] ONE_Q = 32'sd65536;
   localparam logic signed [31:0] DAMP_Q = 32'sd55706;
   localparam logic signed [31:0] TELE_Q = 32'sd9830;
   localparam logic signed [31:0] ROUND_Q = 32'sd32768;

   localparam logic [16:0] THRESHOLD_RESET = 17'd655;

   localparam logic [1:0] KIND_GATHER = 2'd0;
   localparam logic [1:0] KIND_APPLY = 2'd1;
   localparam logic [1:0] KIND_INSERT = 2'd2;
   localparam logic [1:0] KIND_DELETE = 2'd3;

   localparam logic REG_FIRST_ROUND = 1'b0;
   localparam logic REG_THRESHOLD = 1'b1;

   typedef struct packed {
      logic is_apply;
      logic is_edge;
      logic is_delete;
      logic [11:0] target_vertex;
      logic [11:0] source_vertex;
      logic signed [31:0] source_delta;
      logic [15:0] source_out_degree;
   } dpr_item_type;

   typedef struct packed {
      logic pad;
      logic signed [31:0] vertex_delta;
      logic signed [31:0] vertex_rank;
      logic [11:0] flagged_vertex;
      logic mark_changed;
      logic activate_next;
      logic done_flag;
   } dpr_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ----- rtl/dpr_front.sv -----
// request intake: classifies request kinds and queues them for the back end
module dpr_front (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [71:0] req_tdata,
   input  logic [1:0] req_tuser,
   input  logic clearing,
   output logic item_valid,
   output dpr_pkg::dpr_item_type item,
   input  logic item_pop
);

   dpr_pkg::dpr_item_type entry_ff [dpr_pkg::QUEUE_DEPTH];
   dpr_pkg::dpr_item_type cls;
   logic [dpr_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [dpr_pkg::QUEUE_PTR_W:0] count_ff, count_in;
   logic push;

   always_comb begin
      cls = '0;
      cls.target_vertex = req_tdata[11:0];
      cls.source_vertex = req_tdata[23:12];
      cls.source_delta = $signed(req_tdata[55:24]);
      cls.source_out_degree = req_tdata[71:56];
      unique case (req_tuser)
         dpr_pkg::KIND_GATHER: begin
         end
         dpr_pkg::KIND_APPLY: begin
            cls.is_apply = 1'b1;
         end
         dpr_pkg::KIND_INSERT: begin
            cls.is_edge = 1'b1;
         end
         dpr_pkg::KIND_DELETE: begin
            cls.is_edge = 1'b1;
            cls.is_delete = 1'b1;
         end
      endcase
   end

   assign req_tready = (count_ff != (dpr_pkg::QUEUE_PTR_W+1)'(dpr_pkg::QUEUE_DEPTH)) && !clearing;
   assign push = req_tvalid && req_tready;
   assign item_valid = (count_ff != '0);
   assign item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = item_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !item_pop) count_in = count_ff + 1'b1;
      else if (!push && item_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= cls;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/dpr_div.sv -----
// iterative unsigned divider, one quotient bit per cycle
module dpr_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic done,
   output logic [31:0] quotient
);

   logic busy_ff, busy_in, done_ff, done_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [31:0] quo_ff, quo_in;
   logic [16:0] shifted;
   logic ge;

   assign shifted = {rem_ff, quo_ff[31]};
   assign ge = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? 16'(shifted - {1'b0, dvs_ff}) : shifted[15:0];
         quo_in = {quo_ff[30:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/dpr_back.sv -----
// execution sequencer with the vertex stores, result register and clear pass
module dpr_back #(
   parameter int VERTEX_COUNT = dpr_pkg::VERTEX_COUNT_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic first_round,
   input  logic [16:0] change_threshold,
   input  logic item_valid,
   input  dpr_pkg::dpr_item_type item,
   output logic item_pop,
   output logic clearing,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [79:0] rsp_tdata
);

   localparam int IDX_W = $clog2(VERTEX_COUNT);
   localparam logic [23:0] RECIP_V = 24'((2**24 + VERTEX_COUNT - 1) / VERTEX_COUNT);
   localparam logic [20:0] VC_V = 21'(VERTEX_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VERTEX_COUNT - 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_MOD1 = 4'd2;
   localparam logic [3:0] S_MOD2 = 4'd3;
   localparam logic [3:0] S_READ = 4'd4;
   localparam logic [3:0] S_FETCH = 4'd5;
   localparam logic [3:0] S_DIV = 4'd6;
   localparam logic [3:0] S_EDGE = 4'd7;
   localparam logic [3:0] S_CMP = 4'd8;
   localparam logic [3:0] S_DAMP = 4'd9;
   localparam logic [3:0] S_AP1 = 4'd10;
   localparam logic [3:0] S_AP2 = 4'd11;
   localparam logic [3:0] S_AP3 = 4'd12;
   localparam logic [3:0] S_AP4 = 4'd13;
   localparam logic [3:0] S_RESP = 4'd14;

   typedef struct packed {
      dpr_pkg::dpr_item_type it;
      logic [11:0] mq_t;
      logic [11:0] mq_s;
      logic [IDX_W-1:0] idx_t;
      logic [IDX_W-1:0] idx_s;
      logic [11:0] flag_t;
      logic [11:0] flag_s;
      logic neg;
      logic signed [31:0] q;
      logic signed [49:0] prod;
      logic signed [31:0] d;
      logic signed [31:0] rank_new;
      logic signed [31:0] delta_new;
      logic signed [31:0] sum_new;
      logic signed [33:0] cmp_a;
      logic signed [49:0] thr_prod;
      dpr_pkg::dpr_rsp_type res;
   } work_type;

   logic [3:0] state_ff, state_in;
   work_type work_ff, work_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic rsp_valid_ff, rsp_valid_in;
   dpr_pkg::dpr_rsp_type rsp_ff, rsp_in;

   logic signed [31:0] rank_mem [VERTEX_COUNT];
   logic signed [31:0] delta_mem [VERTEX_COUNT];
   logic signed [31:0] sum_mem [VERTEX_COUNT];
   logic signed [31:0] rd_rank_t_ff, rd_rank_s_ff, rd_delta_t_ff, rd_sum_t_ff;

   logic rank_we, delta_we, sum_we;
   logic [IDX_W-1:0] rank_wa, delta_wa, sum_wa;
   logic signed [31:0] rank_wd, delta_wd, sum_wd;

   logic div_start, div_done;
   logic [31:0] div_dividend, div_quotient;

   logic signed [34:0] diff_t, diff_s;
   logic [11:0] red_t, red_s;
   logic signed [31:0] div_src;
   logic signed [33:0] p16;
   logic slot_free;

   dpr_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(div_dividend),
      .divisor(work_ff.it.source_out_degree),
      .done(div_done),
      .quotient(div_quotient)
   );

   assign diff_t = $signed({23'b0, work_ff.it.target_vertex})
                 - $signed({2'b0, 33'(work_ff.mq_t * VC_V)});
   assign diff_s = $signed({23'b0, work_ff.it.source_vertex})
                 - $signed({2'b0, 33'(work_ff.mq_s * VC_V)});
   assign red_t = diff_t[34] ? 12'(diff_t + $signed({14'b0, VC_V})) : diff_t[11:0];
   assign red_s = diff_s[34] ? 12'(diff_s + $signed({14'b0, VC_V})) : diff_s[11:0];
   assign div_src = work_ff.it.is_edge ? rd_rank_s_ff : work_ff.it.source_delta;
   assign div_dividend = div_src[31] ? 32'(-div_src) : div_src;
   assign p16 = work_ff.prod[49:16];
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign clearing = (state_ff == S_CLEAR);

   always_comb begin
      state_in = state_ff;
      work_in = work_ff;
      clr_in = clr_ff;
      item_pop = 1'b0;
      div_start = 1'b0;
      rank_we = 1'b0;
      delta_we = 1'b0;
      sum_we = 1'b0;
      rank_wa = work_ff.idx_t;
      delta_wa = work_ff.idx_t;
      sum_wa = work_ff.idx_t;
      rank_wd = work_ff.rank_new;
      delta_wd = work_ff.delta_new;
      sum_wd = work_ff.sum_new;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in = rsp_ff;
      unique case (state_ff)
         S_CLEAR: begin
            rank_we = 1'b1;
            delta_we = 1'b1;
            sum_we = 1'b1;
            rank_wa = clr_ff;
            delta_wa = clr_ff;
            sum_wa = clr_ff;
            rank_wd = '0;
            delta_wd = dpr_pkg::ONE_Q;
            sum_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               work_in.it = item;
               state_in = S_MOD1;
            end
         end
         S_MOD1: begin
            work_in.mq_t = 12'(({24'b0, work_ff.it.target_vertex} * {12'b0, RECIP_V}) >> 24);
            work_in.mq_s = 12'(({24'b0, work_ff.it.source_vertex} * {12'b0, RECIP_V}) >> 24);
            state_in = S_MOD2;
         end
         S_MOD2: begin
            work_in.flag_t = red_t;
            work_in.flag_s = red_s;
            work_in.idx_t = IDX_W'(red_t);
            work_in.idx_s = IDX_W'(red_s);
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_FETCH;
         end
         S_FETCH: begin
            work_in.rank_new = rd_rank_t_ff;
            work_in.delta_new = rd_delta_t_ff;
            if (work_ff.it.is_apply) begin
               if (!first_round && rd_sum_t_ff == '0) begin
                  delta_we = 1'b1;
                  delta_wd = '0;
                  work_in.res = '0;
                  work_in.res.done_flag = 1'b1;
                  work_in.res.flagged_vertex = work_ff.flag_t;
                  work_in.res.vertex_rank = rd_rank_t_ff;
                  state_in = S_RESP;
               end else begin
                  state_in = S_DAMP;
               end
            end else if (work_ff.it.source_out_degree == '0) begin
               work_in.q = '0;
               state_in = S_EDGE;
            end else begin
               div_start = 1'b1;
               work_in.neg = div_src[31];
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               work_in.q = work_ff.neg ? 32'(-div_quotient) : div_quotient;
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            if (work_ff.it.is_delete)
               work_in.sum_new = dpr_pkg::sat32(34'(rd_sum_t_ff) - 34'(work_ff.q));
            else
               work_in.sum_new = dpr_pkg::sat32(34'(rd_sum_t_ff) + 34'(work_ff.q));
            work_in.thr_prod = $signed({1'b0, change_threshold}) * rd_rank_t_ff;
            work_in.cmp_a = 34'(work_ff.q);
            state_in = S_CMP;
         end
         S_CMP: begin
            sum_we = 1'b1;
            work_in.res = '0;
            work_in.res.vertex_rank = rd_rank_t_ff;
            work_in.res.vertex_delta = rd_delta_t_ff;
            if (work_ff.it.is_edge) begin
               work_in.res.flagged_vertex = work_ff.flag_s;
               if ($signed({work_ff.cmp_a, 16'b0}) > work_ff.thr_prod) begin
                  work_in.res.activate_next = 1'b1;
                  work_in.res.mark_changed = 1'b1;
                  work_in.res.done_flag = work_ff.it.is_delete;
               end
            end else begin
               work_in.res.flagged_vertex = work_ff.flag_t;
            end
            state_in = S_RESP;
         end
         S_DAMP: begin
            work_in.prod = rd_sum_t_ff * dpr_pkg::DAMP_Q + 50'(dpr_pkg::ROUND_Q);
            state_in = S_AP1;
         end
         S_AP1: begin
            work_in.d = first_round ? dpr_pkg::sat32(p16 + 34'(dpr_pkg::TELE_Q))
                                    : dpr_pkg::sat32(p16);
            state_in = S_AP2;
         end
         S_AP2: begin
            work_in.rank_new = dpr_pkg::sat32(34'(rd_rank_t_ff) + 34'(work_ff.d));
            work_in.delta_new = first_round
                              ? dpr_pkg::sat32(34'(work_ff.d) - 34'(dpr_pkg::ONE_Q))
                              : work_ff.d;
            state_in = S_AP3;
         end
         S_AP3: begin
            rank_we = 1'b1;
            delta_we = 1'b1;
            sum_we = 1'b1;
            sum_wd = '0;
            work_in.thr_prod = $signed({1'b0, change_threshold}) * work_ff.rank_new;
            work_in.cmp_a = work_ff.delta_new[31] ? -34'(work_ff.delta_new)
                                                  : 34'(work_ff.delta_new);
            state_in = S_AP4;
         end
         S_AP4: begin
            work_in.res = '0;
            work_in.res.flagged_vertex = work_ff.flag_t;
            work_in.res.vertex_rank = work_ff.rank_new;
            work_in.res.vertex_delta = work_ff.delta_new;
            if ($signed({work_ff.cmp_a, 16'b0}) > work_ff.thr_prod)
               work_in.res.activate_next = 1'b1;
            else
               work_in.res.done_flag = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = work_ff.res;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rank_we) rank_mem[rank_wa] <= rank_wd;
      rd_rank_t_ff <= rank_mem[work_ff.idx_t];
      rd_rank_s_ff <= rank_mem[work_ff.idx_s];
   end

   always_ff @(posedge clock) begin
      if (delta_we) delta_mem[delta_wa] <= delta_wd;
      rd_delta_t_ff <= delta_mem[work_ff.idx_t];
   end

   always_ff @(posedge clock) begin
      if (sum_we) sum_mem[sum_wa] <= sum_wd;
      rd_sum_t_ff <= sum_mem[work_ff.idx_t];
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_ff;

endmodule

// ----- rtl/delta_pagerank_vertex_engine.sv -----
// top level of the delta pagerank vertex engine
// usage:
//   req_ channel: one beat per request, kind on tuser, vertices, source delta
//   and out-degree on tdata. rsp_ channel: one beat per request with the
//   flags, flagged vertex and the target's rank and delta after the request.
//   csr_ channel: writes first_round (index 0) and change_threshold
//   (index 1); always ready, write only while no request is in flight.
// execution:
//   one request is executed at a time. gather, insert and delete wait on
//   the bit-serial divider (not with a zero out-degree); an apply in a later
//   round that finds a zero sum skips the damping steps. a two-entry queue
//   takes two more requests while one executes.
// reset:
//   resets the control registers, then sweeps all VERTEX_COUNT entries of the
//   rank, delta and sum stores (one per cycle); req_tready stays low during
//   the sweep.
// stall:
//   a held response beat blocks only the next response; the queue keeps
//   taking requests until full.
module delta_pagerank_vertex_engine #(
   parameter int VERTEX_COUNT = dpr_pkg::VERTEX_COUNT_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // target_vertex[11:0], source_vertex[23:12], source_delta[55:24],
   // source_out_degree[71:56]
   input  logic [71:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // done_flag[0], activate_next[1], mark_changed[2], flagged_vertex[14:3],
   // vertex_rank[46:15], vertex_delta[78:47], zero[79]
   output logic [79:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [16:0] csr_data
);

   logic first_round_ff, first_round_in;
   logic [16:0] threshold_ff, threshold_in;
   logic clearing, item_valid, item_pop;
   dpr_pkg::dpr_item_type item;

   assign csr_ready = 1'b1;

   always_comb begin
      first_round_in = first_round_ff;
      threshold_in = threshold_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dpr_pkg::REG_FIRST_ROUND: first_round_in = csr_data[0];
            dpr_pkg::REG_THRESHOLD: threshold_in = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_round_ff <= 1'b1;
         threshold_ff <= dpr_pkg::THRESHOLD_RESET;
      end else begin
         first_round_ff <= first_round_in;
         threshold_ff <= threshold_in;
      end
   end

   dpr_front u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .clearing(clearing),
      .item_valid(item_valid),
      .item(item),
      .item_pop(item_pop)
   );

   dpr_back #(
      .VERTEX_COUNT(VERTEX_COUNT)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .first_round(first_round_ff),
      .change_threshold(threshold_ff),
      .item_valid(item_valid),
      .item(item),
      .item_pop(item_pop),
      .clearing(clearing),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

endmodule
